// ===== sv/lgs_pkg.sv =====
// Shared types and constants for the toroidal Life grid stepper.
// No dependencies; imported by every module of the block.
package lgs_pkg;

    localparam int GRID_W  = 64;  // grid image width, bit row*8+col
    localparam int ROW_W   = 8;   // bits per row slot in the image
    localparam int COUNT_W = 6;   // half-grid live count
    localparam int POP_W   = 4;   // live cells in one row

    localparam logic OP_MARK = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Neighbor-count rules
    localparam logic [3:0] NBR_BIRTH = 4'd3;
    localparam logic [3:0] NBR_MIN   = 4'd2;
    localparam logic [3:0] NBR_MAX   = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic busy;   // not taking transactions
        logic mark;   // queue a birth for the input cell
        logic apply;  // apply pending changes, clear counts
        logic scan;   // evaluate the current row
        logic load;   // write the result register
    } t_ctl;

endpackage

// ===== sv/toroidal_life_grid_stepper.sv =====
// Top level of the toroidal Life grid stepper: grid, pending-change masks,
// result register. Depends on lgs_pkg, lgs_ctrl and lgs_row_unit.

// Conway Life on a GRID_SIDE x GRID_SIDE torus (GRID_SIDE 4..8) with a
// map of pending changes. A mark transaction (op 0) queues a birth for
// cell (row, col), cancelling any queued death; marks outside the grid
// are dropped. It produces no result. A tick transaction (op 1) applies
// all queued births and deaths to the live grid at the accepting edge
// and clears the map, then one shared row evaluator walks the grid one
// row per cycle, queuing new births and deaths and counting live cells,
// and finally the result is loaded into the output register with the
// toggled phase bit. After a tick is accepted the input stays stalled
// through the scan of every row and the load state; the load waits
// while a previous result is still stalled at the output.
// Grid image bit row*8+col is a cell; bits of cells beyond GRID_SIDE read
// zero. Marks are accepted while an earlier result is still waiting.
module toroidal_life_grid_stepper #(
    parameter int GRID_SIDE = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [2:0]                    i_col,
    input  logic [2:0]                    i_row,
    // result channel
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [lgs_pkg::GRID_W-1:0]    o_grid_image,
    output logic                          o_phase,
    output logic                          o_all_empty,
    output logic [lgs_pkg::COUNT_W-1:0]   o_top_count,
    output logic [lgs_pkg::COUNT_W-1:0]   o_bottom_count
);
    import lgs_pkg::*;

    localparam int RW = $clog2(GRID_SIDE);
    localparam logic [2:0]    SIDE_M1  = 3'(GRID_SIDE - 1);
    localparam logic [RW-1:0] LAST_ROW = RW'(GRID_SIDE - 1);
    localparam logic [RW-1:0] HALF_ROW = RW'(GRID_SIDE / 2);

    t_ctl          w_ctl;
    logic [RW-1:0] w_row;
    logic          w_out_busy;

    // live grid and pending changes (birth and death never both set)
    logic [GRID_W-1:0]  r_grid;
    logic [GRID_W-1:0]  r_birth;
    logic [GRID_W-1:0]  r_death;
    logic               r_phase;
    logic [COUNT_W-1:0] r_top, r_bottom;

    // result register
    logic               r_out_valid;
    logic [GRID_W-1:0]  r_out_grid;
    logic               r_out_phase;
    logic               r_out_empty;
    logic [COUNT_W-1:0] r_out_top, r_out_bottom;

    // row evaluator hookup
    logic [RW-1:0]      w_up_idx, w_dn_idx;
    logic [ROW_W-1:0]   w_up, w_cur, w_dn;
    logic [ROW_W-1:0]   w_birth_row, w_death_row;
    logic [POP_W-1:0]   w_pop;
    logic [5:0]         w_mark_bit;
    logic               w_mark_ok;

    assign w_out_busy = r_out_valid && i_stall;

    lgs_ctrl #(
        .GRID_SIDE (GRID_SIDE)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_op       (i_op),
        .i_out_busy (w_out_busy),
        .o_ctl      (w_ctl),
        .o_row      (w_row)
    );

    // wrap-around row neighbors
    assign w_up_idx = (w_row == '0) ? LAST_ROW : w_row - RW'(1);
    assign w_dn_idx = (w_row == LAST_ROW) ? '0 : w_row + RW'(1);

    assign w_up  = r_grid[{3'(w_up_idx), 3'b000} +: ROW_W];
    assign w_cur = r_grid[{3'(w_row),    3'b000} +: ROW_W];
    assign w_dn  = r_grid[{3'(w_dn_idx), 3'b000} +: ROW_W];

    lgs_row_unit #(
        .GRID_SIDE (GRID_SIDE)
    ) u_row_unit (
        .i_up    (w_up),
        .i_cur   (w_cur),
        .i_dn    (w_dn),
        .o_birth (w_birth_row),
        .o_death (w_death_row),
        .o_pop   (w_pop)
    );

    assign w_mark_bit = {i_row, i_col};
    assign w_mark_ok  = (i_row <= SIDE_M1) && (i_col <= SIDE_M1);

    // grid state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid  <= '0;
            r_birth <= '0;
            r_death <= '0;
            r_phase <= 1'b0;
        end else begin
            if (w_ctl.mark && w_mark_ok) begin
                r_birth[w_mark_bit] <= 1'b1;
                r_death[w_mark_bit] <= 1'b0;
            end
            if (w_ctl.apply) begin
                r_grid  <= (r_grid | r_birth) & ~r_death;
                r_birth <= '0;
                r_death <= '0;
            end
            // each row is rewritten once per scan, after the clear
            if (w_ctl.scan) begin
                r_birth[{3'(w_row), 3'b000} +: ROW_W] <= w_birth_row;
                r_death[{3'(w_row), 3'b000} +: ROW_W] <= w_death_row;
            end
            if (w_ctl.load) begin
                r_phase <= ~r_phase;
            end
        end
    end

    // half-grid live counts, built up row by row
    always_ff @(posedge i_clk) begin
        if (w_ctl.apply) begin
            r_top    <= '0;
            r_bottom <= '0;
        end else if (w_ctl.scan) begin
            if (w_row < HALF_ROW) begin
                r_top <= r_top + COUNT_W'(w_pop);
            end else begin
                r_bottom <= r_bottom + COUNT_W'(w_pop);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_out_grid   <= r_grid;
            r_out_phase  <= ~r_phase;
            r_out_empty  <= (r_grid == '0);
            r_out_top    <= r_top;
            r_out_bottom <= r_bottom;
        end
    end

    assign o_stall        = w_ctl.busy;
    assign o_valid        = r_out_valid;
    assign o_grid_image   = r_out_grid;
    assign o_phase        = r_out_phase;
    assign o_all_empty    = r_out_empty;
    assign o_top_count    = r_out_top;
    assign o_bottom_count = r_out_bottom;

endmodule

// ===== sv/lgs_row_unit.sv =====
// Shared row evaluator: neighbor counts, new marks and popcount for one row.
// Depends on lgs_pkg.
module lgs_row_unit #(
    parameter int GRID_SIDE = 8
) (
    input  logic [lgs_pkg::ROW_W-1:0] i_up,
    input  logic [lgs_pkg::ROW_W-1:0] i_cur,
    input  logic [lgs_pkg::ROW_W-1:0] i_dn,
    output logic [lgs_pkg::ROW_W-1:0] o_birth,
    output logic [lgs_pkg::ROW_W-1:0] o_death,
    output logic [lgs_pkg::POP_W-1:0] o_pop
);
    import lgs_pkg::*;

    genvar c;
    for (c = 0; c < ROW_W; c++) begin : g_cell
        if (c < GRID_SIDE) begin : g_in
            localparam int L = (c == 0) ? GRID_SIDE - 1 : c - 1;
            localparam int R = (c == GRID_SIDE - 1) ? 0 : c + 1;
            logic [3:0] w_n;

            assign w_n = 4'(i_up[L]) + 4'(i_up[c]) + 4'(i_up[R])
                       + 4'(i_cur[L]) + 4'(i_cur[R])
                       + 4'(i_dn[L]) + 4'(i_dn[c]) + 4'(i_dn[R]);
            assign o_birth[c] = (w_n == NBR_BIRTH) && !i_cur[c];
            assign o_death[c] = i_cur[c] && ((w_n < NBR_MIN) || (w_n > NBR_MAX));
        end else begin : g_out
            assign o_birth[c] = 1'b0;
            assign o_death[c] = 1'b0;
        end
    end

    // cells beyond the grid side are always dead
    assign o_pop = POP_W'($countones(i_cur));

endmodule

// ===== sv/lgs_ctrl.sv =====
// Sequencer: takes transactions, steps the row evaluator over the grid,
// and hands the result to the output register. Depends on lgs_pkg.
module lgs_ctrl #(
    parameter int GRID_SIDE = 8,
    localparam int RW = $clog2(GRID_SIDE)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_op,
    input  logic                i_out_busy,
    output lgs_pkg::t_ctl       o_ctl,
    output logic [RW-1:0]       o_row
);
    import lgs_pkg::*;

    localparam logic [RW-1:0] LAST_ROW = RW'(GRID_SIDE - 1);

    t_state        r_state, n_state;
    logic [RW-1:0] r_row, n_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    if (i_op == OP_MARK) begin
                        o_ctl.mark = 1'b1;
                    end else begin
                        o_ctl.apply = 1'b1;
                        n_row       = '0;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_ctl.busy = 1'b1;
                o_ctl.scan = 1'b1;
                if (r_row == LAST_ROW) begin
                    n_state = ST_LOAD;
                end else begin
                    n_row = r_row + RW'(1);
                end
            end
            ST_LOAD: begin
                o_ctl.busy = 1'b1;
                if (!i_out_busy) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_row = r_row;

endmodule

// ===== tb/toroidal_life_grid_stepper_tb.sv =====
// Self-checking testbench for toroidal_life_grid_stepper: directed table, then random
// mark/tick traffic against a Life predictor. Depends on lgs_pkg and the block's RTL.
module toroidal_life_grid_stepper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lgs_pkg::*;

    localparam int SIDE        = 8;        // grid side the block is built with
    localparam int N_ITEMS     = 1600;     // stimulus stops after about this many
    localparam int HOLD_CYCLES = 300;      // long receiver hold-off
    localparam int LIMIT       = 400_000;  // cycle budget for the whole run
    localparam int N_DIR       = 20;

    // pending change of one cell
    typedef enum logic [1:0] {
        CHG_NONE,
        CHG_BIRTH,
        CHG_DEATH
    } t_chg;

    // one generation report, as the result channel carries it
    typedef struct packed {
        logic [GRID_W-1:0]  image;
        logic               phase;
        logic               empty;
        logic [COUNT_W-1:0] top;
        logic [COUNT_W-1:0] bottom;
    } t_gen;

    // directed row: typed set means the expected report is given in the row
    typedef struct packed {
        logic       op;
        logic [2:0] col;
        logic [2:0] row;
        logic       typed;
        t_gen       want;
    } t_dir_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_op;
    logic [2:0]          i_col;
    logic [2:0]          i_row;
    logic                o_valid;
    logic                i_stall;
    logic [GRID_W-1:0]   o_grid_image;
    logic                o_phase;
    logic                o_all_empty;
    logic [COUNT_W-1:0]  o_top_count;
    logic [COUNT_W-1:0]  o_bottom_count;

    // predictor state: live grid, pending-change map, phase
    logic [GRID_W-1:0] life_grid;
    t_chg              queued_chg [64];
    logic              life_phase;

    t_gen     gen_q [$];          // reports still owed by the block, oldest first
    t_dir_row dir_tab [N_DIR];
    int       errors    = 0;
    int       items_sent = 0;
    int       cycle_cnt = 0;
    bit       calm      = 1'b0;   // no idling on either side while set
    bit       hold_req  = 1'b0;   // sender asks the receiver for a long hold-off

    toroidal_life_grid_stepper #(
        .GRID_SIDE(SIDE)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_op           (i_op),
        .i_col          (i_col),
        .i_row          (i_row),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_grid_image   (o_grid_image),
        .o_phase        (o_phase),
        .o_all_empty    (o_all_empty),
        .o_top_count    (o_top_count),
        .o_bottom_count (o_bottom_count)
    );

    always #5 i_clk = ~i_clk;

    // Advance the Life predictor by one transaction. A mark only touches the
    // map; a tick applies the map, re-evaluates every cell on the updated grid
    // and reports the grid.
    task automatic life_step(input logic op, input logic [2:0] col, input logic [2:0] row,
                             output bit made, output t_gen res);
        int n;
        int b;
        int top;
        int bottom;
        top    = 0;
        bottom = 0;
        made   = 1'b0;
        res    = '0;
        if (op == OP_MARK) begin
            // a birth mark overrides a queued death; off-grid marks are dropped
            if (col < SIDE && row < SIDE) begin
                queued_chg[8 * row + col] = CHG_BIRTH;
            end
        end else begin
            for (int r = 0; r < SIDE; r++) begin
                for (int c = 0; c < SIDE; c++) begin
                    b = 8 * r + c;
                    if (queued_chg[b] == CHG_BIRTH) begin
                        life_grid[b] = 1'b1;
                    end else if (queued_chg[b] == CHG_DEATH) begin
                        life_grid[b] = 1'b0;
                    end
                    queued_chg[b] = CHG_NONE;
                end
            end
            // neighbors wrap on both axes
            for (int r = 0; r < SIDE; r++) begin
                for (int c = 0; c < SIDE; c++) begin
                    b = 8 * r + c;
                    n = 0;
                    for (int dr = -1; dr <= 1; dr++) begin
                        for (int dc = -1; dc <= 1; dc++) begin
                            if (dr != 0 || dc != 0) begin
                                n += int'(life_grid[8 * ((r + SIDE + dr) % SIDE)
                                                    + ((c + SIDE + dc) % SIDE)]);
                            end
                        end
                    end
                    if (n == 3 && !life_grid[b]) begin
                        queued_chg[b] = CHG_BIRTH;
                    end
                    if ((n < 2 || n > 3) && life_grid[b]) begin
                        queued_chg[b] = CHG_DEATH;
                    end
                    if (life_grid[b]) begin
                        if (r < SIDE / 2) begin
                            top++;
                        end else begin
                            bottom++;
                        end
                    end
                end
            end
            life_phase = ~life_phase;
            res.image  = life_grid;
            res.phase  = life_phase;
            res.empty  = (life_grid == '0);
            res.top    = top[COUNT_W-1:0];
            res.bottom = bottom[COUNT_W-1:0];
            made       = 1'b1;
        end
    endtask

    // Offer one transaction and wait until it is taken. Idle gaps go in front
    // of the offer so that valid is never dropped and raised in one step.
    task automatic send(input logic op, input logic [2:0] col, input logic [2:0] row,
                        input bit typed, input t_gen want);
        bit   made;
        t_gen res;
        if (!calm && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 31);
        end
        i_valid <= 1'b1;
        i_op    <= op;
        i_col   <= col;
        i_row   <= row;
        do @(posedge i_clk); while (o_stall);
        life_step(op, col, row, made, res);
        if (made) begin
            gen_q.push_back(typed ? want : res);
        end
        items_sent++;
    endtask

    task automatic send_mark(input int row, input int col);
        send(OP_MARK, col[2:0], row[2:0], 1'b0, '0);
    endtask

    task automatic send_tick();
        send(OP_TICK, 3'($urandom_range(7)), 3'($urandom_range(7)), 1'b0, '0);
    endtask

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Result channel: every accepted report is matched against the oldest
    // expectation. Values read here are the ones in place before the edge.
    always @(posedge i_clk) begin : report_mon
        t_gen want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (gen_q.size() == 0) begin
                $display("%0t: report with none expected, expected nothing, got image %h",
                         $time, o_grid_image);
                errors++;
            end else begin
                want = gen_q.pop_front();
                check_field("grid_image", want.image, o_grid_image);
                check_field("phase", want.phase, o_phase);
                check_field("all_empty", want.empty, o_all_empty);
                check_field("top_count", want.top, o_top_count);
                check_field("bottom_count", want.bottom, o_bottom_count);
            end
        end
    end

    // Receiver: random stalls, none while calm, plus one long hold-off on
    // request so that the block backs up into its input.
    initial begin : rx_side
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= (!calm && $urandom_range(99) < 31);
        end
    end

    initial begin : watchdog
        while (cycle_cnt < LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stim
        int  kind;
        int  r0;
        int  c0;
        int  len;
        bit  hold_done;
        bit  pause_done;
        bit  vert;
        int  gl_r [5];
        int  gl_c [5];
        hold_done  = 1'b0;
        pause_done = 1'b0;
        gl_r = '{0, 1, 2, 2, 2};
        gl_c = '{1, 2, 0, 1, 2};

        // Directed part. Rows with typed reports: tick right after reset,
        // two opposite corners (diagonal neighbors across the wrap) that
        // both die, and a fresh blinker.
        dir_tab = '{
            '{OP_TICK, 3'd0, 3'd0, 1'b1, '{64'h0, 1'b1, 1'b1, 6'd0, 6'd0}},
            '{OP_MARK, 3'd0, 3'd0, 1'b0, '0},
            '{OP_MARK, 3'd7, 3'd7, 1'b0, '0},
            '{OP_MARK, 3'd7, 3'd7, 1'b0, '0},   // repeated mark keeps the birth
            '{OP_TICK, 3'd5, 3'd2, 1'b1,
              '{64'h8000_0000_0000_0001, 1'b0, 1'b0, 6'd1, 6'd1}},
            '{OP_TICK, 3'd7, 3'd7, 1'b1, '{64'h0, 1'b1, 1'b1, 6'd0, 6'd0}},
            '{OP_MARK, 3'd2, 3'd3, 1'b0, '0},
            '{OP_MARK, 3'd3, 3'd3, 1'b0, '0},
            '{OP_MARK, 3'd4, 3'd3, 1'b0, '0},
            '{OP_TICK, 3'd0, 3'd0, 1'b1,
              '{64'h0000_0000_1C00_0000, 1'b0, 1'b0, 6'd3, 6'd0}},
            '{OP_MARK, 3'd2, 3'd3, 1'b0, '0},   // birth replaces a queued death
            '{OP_MARK, 3'd3, 3'd3, 1'b0, '0},   // mark on a live cell
            '{OP_TICK, 3'd1, 3'd6, 1'b0, '0},
            '{OP_TICK, 3'd6, 3'd1, 1'b0, '0},
            '{OP_MARK, 3'd0, 3'd7, 1'b0, '0},   // block split over all four corners
            '{OP_MARK, 3'd7, 3'd7, 1'b0, '0},
            '{OP_MARK, 3'd0, 3'd0, 1'b0, '0},
            '{OP_MARK, 3'd7, 3'd0, 1'b0, '0},
            '{OP_TICK, 3'd3, 3'd4, 1'b0, '0},
            '{OP_TICK, 3'd4, 3'd3, 1'b0, '0}
        };

        life_grid  = '0;
        life_phase = 1'b0;
        foreach (queued_chg[i]) queued_chg[i] = CHG_NONE;

        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_op    <= OP_MARK;
        i_col   <= 3'd0;
        i_row   <= 3'd0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIR; i++) begin
            send(dir_tab[i].op, dir_tab[i].col, dir_tab[i].row,
                 dir_tab[i].typed, dir_tab[i].want);
        end

        // Random part: mostly plant-and-run sequences so the grid keeps
        // evolving, with dense fills for the count extremes and some noise.
        while (items_sent < N_ITEMS) begin
            calm = (items_sent >= 700 && items_sent < 950);
            if (!hold_done && items_sent >= 400) begin
                hold_req  = 1'b1;     // sender keeps offering during the hold
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= 1200) begin
                // drain: no offer until every owed report has come back
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (gen_q.size() != 0) @(posedge i_clk);
                pause_done = 1'b1;
            end

            kind = $urandom_range(99);
            if (kind < 6) begin
                // full grid, top half only or bottom half only
                len = $urandom_range(2);
                for (int b = 0; b < 64; b++) begin
                    if (len == 0 || (len == 1 && b < 32) || (len == 2 && b >= 32)) begin
                        send_mark(b / 8, b % 8);
                    end
                end
                repeat ($urandom_range(1, 3)) send_tick();
            end else if (kind < 18) begin
                // noise: ops and cells at random
                repeat ($urandom_range(1, 8)) begin
                    send(1'($urandom_range(1)), 3'($urandom_range(7)),
                         3'($urandom_range(7)), 1'b0, '0);
                end
            end else if (kind < 45) begin
                // glider or a short line at a random spot, then let it run
                r0 = $urandom_range(7);
                c0 = $urandom_range(7);
                if ($urandom_range(1)) begin
                    for (int k = 0; k < 5; k++) begin
                        send_mark((r0 + gl_r[k]) % SIDE, (c0 + gl_c[k]) % SIDE);
                    end
                end else begin
                    len  = $urandom_range(3, 5);
                    vert = 1'($urandom_range(1));
                    for (int k = 0; k < len; k++) begin
                        send_mark(vert ? (r0 + k) % SIDE : r0, vert ? c0 : (c0 + k) % SIDE);
                    end
                end
                repeat ($urandom_range(2, 8)) send_tick();
            end else begin
                // sparse random marks, then a few generations
                repeat ($urandom_range(0, 10)) send_mark($urandom_range(7), $urandom_range(7));
                repeat ($urandom_range(1, 4)) send_tick();
            end
        end

        i_valid <= 1'b0;
        while (gen_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);    // catch any stray report
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
sv/lgs_pkg.sv
sv/lgs_row_unit.sv
sv/lgs_ctrl.sv
sv/toroidal_life_grid_stepper.sv
tb/toroidal_life_grid_stepper_tb.sv
